@@ rtl/etca_pkg.sv @@
package etca_pkg;

  localparam int IDX_W   = 10;
  localparam int COORD_W = 32;
  localparam int TAN_W   = 18;
  localparam int SUM_W   = 32;
  localparam int ONE_Q16 = 65536;

  localparam int IN_DATA_W  = 152;
  localparam int OUT_DATA_W = 104;

  localparam int ROOT_STEPS = 32;
  localparam int DIV_STEPS  = 17;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_EDGE  = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_CLEAR_WAIT,
    S_TANGENT,
    S_RD0,
    S_WR0,
    S_RD1,
    S_WR1,
    S_READ,
    S_READ_DATA,
    S_FIN
  } ctrl_state_t;

  typedef enum logic [2:0] {
    TS_IDLE,
    TS_NORM,
    TS_SQX,
    TS_SQY,
    TS_ROOT,
    TS_DIV_LOAD,
    TS_DIV,
    TS_DONE
  } tan_state_t;

  typedef struct packed {
    logic                     valid;
    logic                     degenerate;
    logic signed [TAN_W-1:0]  tangent_x;
    logic signed [TAN_W-1:0]  tangent_y;
  } tan_res_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clear;
  } store_req_t;

  function automatic logic signed [SUM_W-1:0] sat_add(
    input logic signed [SUM_W-1:0] a,
    input logic signed [TAN_W-1:0] b
  );
    logic signed [SUM_W:0] r;
    r = (SUM_W+1)'(a) + (SUM_W+1)'(b);
    if (r[SUM_W] != r[SUM_W-1]) begin
      sat_add = r[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sat_add = r[SUM_W-1:0];
    end
  endfunction

endpackage

@@ rtl/etca_store.sv @@
module etca_store #(
  parameter int VERTICES = 1024,
  parameter int AW       = 10
) (
  input  logic                     clk,
  input  logic                     rst,
  input  etca_pkg::store_req_t     req,
  input  logic [AW-1:0]            addr,
  input  logic [2*etca_pkg::SUM_W-1:0] wr_data,
  output logic [2*etca_pkg::SUM_W-1:0] rd_data,
  output logic                     busy
);

  logic [2*etca_pkg::SUM_W-1:0] mem [VERTICES];
  logic [AW-1:0]                cnt;

  // clearing sweep, one entry a cycle, also run straight after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == AW'(VERTICES - 1)) begin
        busy <= 1'b0;
      end
    end else if (req.clear) begin
      busy <= 1'b1;
      cnt  <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[cnt] <= '0;
    end else if (req.wr_en) begin
      mem[addr] <= wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[addr];
    end
  end

endmodule

@@ rtl/etca_tangent.sv @@
module etca_tangent (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [etca_pkg::COORD_W-1:0] first_x,
  input  logic signed [etca_pkg::COORD_W-1:0] first_y,
  input  logic signed [etca_pkg::COORD_W-1:0] second_x,
  input  logic signed [etca_pkg::COORD_W-1:0] second_y,
  output etca_pkg::tan_res_t                  res
);

  etca_pkg::tan_state_t state, state_next;

  logic [31:0] mx, my;
  logic        negx, negy, degen, sel_y;
  logic [63:0] acc, root, rbit;
  logic [4:0]  cnt;
  logic [31:0] rem;
  logic [16:0] num_lo, quo, qx, qy;

  logic signed [32:0] dx, dy;
  logic [31:0]        mmax;
  logic [30:0]        mul_op;
  logic [61:0]        prod;
  logic [63:0]        alu_a, alu_b;
  logic [64:0]        alu_diff;
  logic               alu_ge;
  logic [47:0]        div_num;
  logic [16:0]        q_new, q_sat;

  assign dx   = 33'(second_x) - 33'(first_x);
  assign dy   = 33'(second_y) - 33'(first_y);
  assign mmax = (mx > my) ? mx : my;

  // shared multiplier for the two squares
  assign mul_op = (state == etca_pkg::TS_SQY) ? my[30:0] : mx[30:0];
  assign prod   = mul_op * mul_op;

  // shared subtract and compare, used by the root and the division steps
  always_comb begin
    alu_a = '0;
    alu_b = '0;
    if (state == etca_pkg::TS_ROOT) begin
      alu_a = acc;
      alu_b = root + rbit;
    end else if (state == etca_pkg::TS_DIV) begin
      alu_a = 64'({rem, num_lo[16]});
      alu_b = 64'(root[31:0]);
    end
  end
  assign alu_diff = {1'b0, alu_a} - {1'b0, alu_b};
  assign alu_ge   = ~alu_diff[64];

  assign div_num = {(sel_y ? my : mx), 16'd0} + 48'(root[31:1]);
  assign q_new   = {quo[15:0], alu_ge};
  assign q_sat   = (q_new > 17'(etca_pkg::ONE_Q16)) ? 17'(etca_pkg::ONE_Q16) : q_new;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= etca_pkg::TS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      etca_pkg::TS_IDLE: begin
        if (start) begin
          state_next = (dx == '0 && dy == '0) ? etca_pkg::TS_DONE : etca_pkg::TS_NORM;
        end
      end
      etca_pkg::TS_NORM: begin
        if (mmax < 32'h8000_0000 && mmax >= 32'h4000_0000) begin
          state_next = etca_pkg::TS_SQX;
        end
      end
      etca_pkg::TS_SQX:      state_next = etca_pkg::TS_SQY;
      etca_pkg::TS_SQY:      state_next = etca_pkg::TS_ROOT;
      etca_pkg::TS_ROOT: begin
        if (cnt == 5'(etca_pkg::ROOT_STEPS - 1)) begin
          state_next = etca_pkg::TS_DIV_LOAD;
        end
      end
      etca_pkg::TS_DIV_LOAD: state_next = etca_pkg::TS_DIV;
      etca_pkg::TS_DIV: begin
        if (cnt == 5'(etca_pkg::DIV_STEPS - 1)) begin
          state_next = sel_y ? etca_pkg::TS_DONE : etca_pkg::TS_DIV_LOAD;
        end
      end
      etca_pkg::TS_DONE:     state_next = etca_pkg::TS_IDLE;
      default:               state_next = etca_pkg::TS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state)
      etca_pkg::TS_IDLE: begin
        if (start) begin
          mx    <= dx[32] ? 32'(-dx) : 32'(dx);
          my    <= dy[32] ? 32'(-dy) : 32'(dy);
          negx  <= dx[32];
          negy  <= dy[32];
          degen <= (dx == '0 && dy == '0);
          sel_y <= 1'b0;
          qx    <= '0;
          qy    <= '0;
        end
      end
      etca_pkg::TS_NORM: begin
        // single right shift while above range, coarse left shift while far below range, then single left steps
        if (mmax >= 32'h8000_0000) begin
          mx <= mx >> 1;
          my <= my >> 1;
        end else if (mmax < 32'h0040_0000) begin
          mx <= mx << 8;
          my <= my << 8;
        end else if (mmax < 32'h4000_0000) begin
          mx <= mx << 1;
          my <= my << 1;
        end
      end
      etca_pkg::TS_SQX: begin
        acc <= 64'(prod);
      end
      etca_pkg::TS_SQY: begin
        acc  <= acc + 64'(prod);
        root <= '0;
        rbit <= 64'h4000_0000_0000_0000;
        cnt  <= '0;
      end
      etca_pkg::TS_ROOT: begin
        if (alu_ge) begin
          acc  <= alu_diff[63:0];
          root <= (root >> 1) + rbit;
        end else begin
          root <= root >> 1;
        end
        rbit <= rbit >> 2;
        cnt  <= cnt + 1'b1;
      end
      etca_pkg::TS_DIV_LOAD: begin
        rem    <= 32'(div_num[47:17]);
        num_lo <= div_num[16:0];
        quo    <= '0;
        cnt    <= '0;
      end
      etca_pkg::TS_DIV: begin
        rem    <= alu_ge ? alu_diff[31:0] : {rem[30:0], num_lo[16]};
        num_lo <= num_lo << 1;
        quo    <= q_new;
        cnt    <= cnt + 1'b1;
        if (cnt == 5'(etca_pkg::DIV_STEPS - 1)) begin
          if (sel_y) begin
            qy <= q_sat;
          end else begin
            qx    <= q_sat;
            sel_y <= 1'b1;
          end
        end
      end
      etca_pkg::TS_DONE: begin
      end
      default: begin
      end
    endcase
  end

  assign res.valid      = (state == etca_pkg::TS_DONE);
  assign res.degenerate = degen;
  assign res.tangent_x  = negx ? -$signed(18'(qx)) : $signed(18'(qx));
  assign res.tangent_y  = negy ? -$signed(18'(qy)) : $signed(18'(qy));

endmodule

@@ rtl/edge_tangent_curvature_accumulator_top.sv @@
// Edge tangent curvature accumulator: keeps a saturating Q15.16 (x, y) sum for each of
// VERTICES vertices. A clear beat zeroes every sum, an edge beat forms the Q1.16 unit
// tangent of (second - first) and adds it to the first vertex and subtracts it from the
// second, a read beat returns one vertex's sums; each beat gives exactly one result beat.
// One item is worked at a time and s_tready is low meanwhile. An edge goes through
// normalisation, two squares through one multiplier, a 32-step square root and two
// 17-step divisions on one shared subtract/compare unit, then read-modify-write of
// both vertices on the single-port vertex memory. A zero-length edge skips the
// arithmetic and the memory update. A clear sweeps one memory entry a cycle. After
// reset the memory is swept to zero before the first beat is taken.
// Vertex indices of VERTICES or more are ignored by updates and read back as zero.
module edge_tangent_curvature_accumulator_top #(
  parameter int VERTICES = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // first_vertex, second_vertex, first_x, first_y, second_x, second_y
  input  logic [etca_pkg::IN_DATA_W-1:0] s_tdata,
  // op
  input  logic [1:0]                     s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // tangent_x, tangent_y, sum_x, sum_y
  output logic [etca_pkg::OUT_DATA_W-1:0] m_tdata,
  // degenerate
  output logic                           m_tuser
);

  localparam int AW = $clog2(VERTICES);

  etca_pkg::ctrl_state_t state, state_next;
  etca_pkg::store_req_t  st_req;
  etca_pkg::tan_res_t    tan_res;

  logic [etca_pkg::IDX_W-1:0]        v0, v1;
  logic [16:0]                       v0_ext, v1_ext;
  logic                              v0_ok, v1_ok;
  logic [AW-1:0]                     st_addr;
  logic [2*etca_pkg::SUM_W-1:0]      st_wdata, st_rdata;
  logic                              st_busy;
  logic                              accept, tan_start;
  logic signed [etca_pkg::TAN_W-1:0] res_tx, res_ty;
  logic signed [etca_pkg::SUM_W-1:0] res_sx, res_sy;
  logic                              res_deg;
  logic signed [etca_pkg::SUM_W-1:0] mem_x, mem_y;

  assign accept    = s_tvalid && s_tready;
  assign tan_start = accept && (s_tuser == etca_pkg::OP_EDGE);
  assign s_tready  = (state == etca_pkg::S_IDLE) && !st_busy;

  assign v0_ext = 17'(v0);
  assign v1_ext = 17'(v1);
  assign v0_ok  = v0_ext < 17'(VERTICES);
  assign v1_ok  = v1_ext < 17'(VERTICES);

  assign mem_x = st_rdata[etca_pkg::SUM_W-1:0];
  assign mem_y = st_rdata[2*etca_pkg::SUM_W-1:etca_pkg::SUM_W];

  etca_tangent u_tangent (
    .clk      (clk),
    .rst      (rst),
    .start    (tan_start),
    .first_x  (s_tdata[51:20]),
    .first_y  (s_tdata[83:52]),
    .second_x (s_tdata[115:84]),
    .second_y (s_tdata[147:116]),
    .res      (tan_res)
  );

  etca_store #(
    .VERTICES (VERTICES),
    .AW       (AW)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .req     (st_req),
    .addr    (st_addr),
    .wr_data (st_wdata),
    .rd_data (st_rdata),
    .busy    (st_busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= etca_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    st_req     = '0;
    st_addr    = v0_ext[AW-1:0];
    st_wdata   = {etca_pkg::sat_add(mem_y, res_ty), etca_pkg::sat_add(mem_x, res_tx)};
    unique case (state)
      etca_pkg::S_IDLE: begin
        if (accept) begin
          unique case (etca_pkg::op_t'(s_tuser))
            etca_pkg::OP_CLEAR: state_next = etca_pkg::S_CLEAR;
            etca_pkg::OP_EDGE:  state_next = etca_pkg::S_TANGENT;
            etca_pkg::OP_READ:  state_next = etca_pkg::S_READ;
            default:            state_next = etca_pkg::S_FIN;
          endcase
        end
      end
      etca_pkg::S_CLEAR: begin
        st_req.clear = 1'b1;
        state_next   = etca_pkg::S_CLEAR_WAIT;
      end
      etca_pkg::S_CLEAR_WAIT: begin
        if (!st_busy) begin
          state_next = etca_pkg::S_FIN;
        end
      end
      etca_pkg::S_TANGENT: begin
        if (tan_res.valid) begin
          state_next = tan_res.degenerate ? etca_pkg::S_FIN : etca_pkg::S_RD0;
        end
      end
      etca_pkg::S_RD0: begin
        st_req.rd_en = v0_ok;
        state_next   = v0_ok ? etca_pkg::S_WR0 : etca_pkg::S_RD1;
      end
      etca_pkg::S_WR0: begin
        st_req.wr_en = 1'b1;
        state_next   = etca_pkg::S_RD1;
      end
      etca_pkg::S_RD1: begin
        st_addr      = v1_ext[AW-1:0];
        st_req.rd_en = v1_ok;
        state_next   = v1_ok ? etca_pkg::S_WR1 : etca_pkg::S_FIN;
      end
      etca_pkg::S_WR1: begin
        // same vertex twice: the read above already sees the first update
        st_addr      = v1_ext[AW-1:0];
        st_wdata     = {etca_pkg::sat_add(mem_y, -res_ty), etca_pkg::sat_add(mem_x, -res_tx)};
        st_req.wr_en = 1'b1;
        state_next   = etca_pkg::S_FIN;
      end
      etca_pkg::S_READ: begin
        st_req.rd_en = v0_ok;
        state_next   = v0_ok ? etca_pkg::S_READ_DATA : etca_pkg::S_FIN;
      end
      etca_pkg::S_READ_DATA: begin
        state_next = etca_pkg::S_FIN;
      end
      etca_pkg::S_FIN: begin
        // hand over to the output register once it is free
        if (!m_tvalid || m_tready) begin
          state_next = etca_pkg::S_IDLE;
        end
      end
      default: state_next = etca_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      v0      <= s_tdata[9:0];
      v1      <= s_tdata[19:10];
      res_tx  <= '0;
      res_ty  <= '0;
      res_sx  <= '0;
      res_sy  <= '0;
      res_deg <= 1'b0;
    end
    if (state == etca_pkg::S_TANGENT && tan_res.valid) begin
      res_tx  <= tan_res.tangent_x;
      res_ty  <= tan_res.tangent_y;
      res_deg <= tan_res.degenerate;
    end
    if (state == etca_pkg::S_READ_DATA) begin
      res_sx <= mem_x;
      res_sy <= mem_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == etca_pkg::S_FIN && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == etca_pkg::S_FIN && (!m_tvalid || m_tready)) begin
      m_tdata <= {4'd0, res_sy, res_sx, res_ty, res_tx};
      m_tuser <= res_deg;
    end
  end

  a_edge_starts_tangent: assert property (@(posedge clk) disable iff (rst)
    tan_start |=> state == etca_pkg::S_TANGENT)
    else $error("edge beat did not start the tangent unit");

  a_tangent_result_expected: assert property (@(posedge clk) disable iff (rst)
    tan_res.valid |-> state == etca_pkg::S_TANGENT)
    else $error("tangent result arrived outside an edge item");

  a_degenerate_zero: assert property (@(posedge clk) disable iff (rst)
    tan_res.valid && tan_res.degenerate |->
      tan_res.tangent_x == '0 && tan_res.tangent_y == '0)
    else $error("zero-length edge with a non-zero tangent");

  a_tangent_bounded: assert property (@(posedge clk) disable iff (rst)
    tan_res.valid |->
      (tan_res.tangent_x <= 18'sd65536 && tan_res.tangent_x >= -18'sd65536 &&
       tan_res.tangent_y <= 18'sd65536 && tan_res.tangent_y >= -18'sd65536))
    else $error("tangent component beyond unit range");

  a_no_write_while_clearing: assert property (@(posedge clk) disable iff (rst)
    st_busy |-> !st_req.wr_en && !st_req.rd_en)
    else $error("memory access during clearing sweep");

endmodule
